### rtl/isbo_pkg.sv
// Shared constants, types and control structures for the integer stack unit.
`default_nettype none
package isbo_pkg;

    localparam int DEPTH  = 256;
    localparam int DATA_W = 32;
    localparam int POS_W  = 12;
    localparam int CMD_W  = 3;
    localparam int STAT_W = 3;
    localparam int FILL_W = 9;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int CMP_W  = (POS_W > CNT_W) ? POS_W : CNT_W;
    localparam int DIV_CNT_W = $clog2(DATA_W + 1);

    typedef logic [DATA_W-1:0]    t_data;
    typedef logic [ADDR_W-1:0]    t_addr;
    typedef logic [CNT_W-1:0]     t_cnt;
    typedef logic [CMP_W-1:0]     t_cmp;
    typedef logic [FILL_W-1:0]    t_fill;
    typedef logic [POS_W-1:0]     t_pos;
    typedef logic [DIV_CNT_W-1:0] t_divcnt;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH = 3'd0,
        CMD_POP  = 3'd1,
        CMD_READ = 3'd2,
        CMD_ADD  = 3'd3,
        CMD_MUL  = 3'd4,
        CMD_DIV  = 3'd5
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_OK      = 3'd0,
        ST_EMPTY   = 3'd1,
        ST_RANGE   = 3'd2,
        ST_DIVZERO = 3'd3,
        ST_FULL    = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        RD_TOP   = 2'd0,
        RD_POS   = 2'd1,
        RD_SWEEP = 2'd2
    } t_rd_sel;

    typedef struct packed {
        logic    load;
        logic    rd_en;
        t_rd_sel rd_sel;
        logic    push_wr;
        logic    pop_dec;
        logic    sweep_clr;
        logic    calc;
        logic    sweep_wr;
        logic    capture;
        logic    st_ld;
        t_status status;
        logic    out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             is_empty;
        logic             is_full;
        logic             pos_oor;
        logic             opnd_zero;
        logic             sweep_last;
        logic             div_done;
        logic             out_free;
    } t_dp_stat;

endpackage
`default_nettype wire

### rtl/integer_stack_with_bulk_ops_unit.sv
// Top level of the bounded integer stack with bulk arithmetic commands.
// Input channel: i_valid, o_stall and the fields i_command, i_operand_value,
// i_position. A transaction is taken when i_valid is high and o_stall is low.
// Output channel: o_valid, i_stall and the fields o_data_out, o_status,
// o_fill_count, o_is_empty. Every input transaction yields one result.
// One command is handled at a time; o_stall is high from acceptance until
// the result has been moved into the output register.
// After acceptance, push, failed commands, undefined codes and bulk commands
// on an empty stack go from decode straight to the result stage; pop and
// read first pass through a memory-read state. Add, multiply and divide
// handle each entry held in turn: each entry is read, processed and written
// back through the entry memory's separate read and write ports, and divide
// waits on the bit-serial divider for every entry.
// The next command is accepted in the cycle after a result is registered,
// even while that result still waits on i_stall; a result that is ready
// while the output register is still held waits until it is taken.
// Synchronous reset empties the stack, drops any pending result and holds
// o_stall high; the memory contents are not cleared, as only written entries
// are ever read.
`default_nettype none
module integer_stack_with_bulk_ops_unit (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    output logic                            o_stall,
    input  wire logic [isbo_pkg::CMD_W-1:0] i_command,
    input  wire logic signed [isbo_pkg::DATA_W-1:0] i_operand_value,
    input  wire isbo_pkg::t_pos             i_position,
    output logic                            o_valid,
    input  wire logic                       i_stall,
    output logic signed [isbo_pkg::DATA_W-1:0] o_data_out,
    output logic [isbo_pkg::STAT_W-1:0]     o_status,
    output isbo_pkg::t_fill                 o_fill_count,
    output logic                            o_is_empty
);

    isbo_pkg::t_dp_cmd  dp_cmd;
    isbo_pkg::t_dp_stat dp_stat;

    isbo_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_stat  (dp_stat),
        .o_cmd   (dp_cmd)
    );

    isbo_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (dp_cmd),
        .o_stat          (dp_stat),
        .i_command       (i_command),
        .i_operand_value (i_operand_value),
        .i_position      (i_position),
        .i_out_stall     (i_stall),
        .o_valid         (o_valid),
        .o_data_out      (o_data_out),
        .o_status        (o_status),
        .o_fill_count    (o_fill_count),
        .o_is_empty      (o_is_empty)
    );

endmodule
`default_nettype wire

### rtl/isbo_div.sv
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
`default_nettype none
module isbo_div (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_start,
    input  wire isbo_pkg::t_data i_dividend,
    input  wire isbo_pkg::t_data i_divisor,
    output logic                o_done,
    output isbo_pkg::t_data     o_quotient
);

    logic                  r_busy;
    logic                  r_done;
    isbo_pkg::t_divcnt     r_cnt;
    isbo_pkg::t_data       r_rem;
    isbo_pkg::t_data       r_quo;
    isbo_pkg::t_data       r_dvs;
    logic                  r_neg;

    logic [isbo_pkg::DATA_W:0] trial;
    logic [isbo_pkg::DATA_W:0] diff;
    logic                      ge;
    isbo_pkg::t_data           abs_a;
    isbo_pkg::t_data           abs_b;

    always_comb begin
        trial = {r_rem, r_quo[isbo_pkg::DATA_W-1]};
        diff  = trial - {1'b0, r_dvs};
        ge    = (trial >= {1'b0, r_dvs});
        abs_a = i_dividend[isbo_pkg::DATA_W-1] ? (~i_dividend + isbo_pkg::t_data'(1))
                                               : i_dividend;
        abs_b = i_divisor[isbo_pkg::DATA_W-1] ? (~i_divisor + isbo_pkg::t_data'(1))
                                              : i_divisor;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == isbo_pkg::t_divcnt'(1))) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= abs_a;
            r_dvs <= abs_b;
            r_neg <= i_dividend[isbo_pkg::DATA_W-1] ^ i_divisor[isbo_pkg::DATA_W-1];
            r_cnt <= isbo_pkg::t_divcnt'(isbo_pkg::DATA_W);
        end else if (r_busy) begin
            r_rem <= ge ? diff[isbo_pkg::DATA_W-1:0] : trial[isbo_pkg::DATA_W-1:0];
            r_quo <= {r_quo[isbo_pkg::DATA_W-2:0], ge};
            r_cnt <= r_cnt - isbo_pkg::t_divcnt'(1);
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_neg ? (~r_quo + isbo_pkg::t_data'(1)) : r_quo;

    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("divider started while busy");
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> r_busy)
        else $error("divider did not begin after start");
    a_fall_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_busy) |-> o_done)
        else $error("divider stopped without signalling completion");

endmodule
`default_nettype wire

### rtl/isbo_datapath.sv
// Stack datapath: entry memory, count, sweep index, arithmetic units and result register.
`default_nettype none
module isbo_datapath (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire isbo_pkg::t_dp_cmd          i_cmd,
    output isbo_pkg::t_dp_stat              o_stat,
    input  wire logic [isbo_pkg::CMD_W-1:0] i_command,
    input  wire logic signed [isbo_pkg::DATA_W-1:0] i_operand_value,
    input  wire isbo_pkg::t_pos             i_position,
    input  wire logic                       i_out_stall,
    output logic                            o_valid,
    output logic signed [isbo_pkg::DATA_W-1:0] o_data_out,
    output logic [isbo_pkg::STAT_W-1:0]     o_status,
    output isbo_pkg::t_fill                 o_fill_count,
    output logic                            o_is_empty
);

    isbo_pkg::t_data              r_mem [isbo_pkg::DEPTH];
    logic [isbo_pkg::CMD_W-1:0]   r_cmd;
    isbo_pkg::t_data              r_opnd;
    isbo_pkg::t_pos               r_pos;
    isbo_pkg::t_cnt               r_count;
    isbo_pkg::t_addr              r_j;
    isbo_pkg::t_data              r_q;
    isbo_pkg::t_data              r_res;
    isbo_pkg::t_data              r_data;
    isbo_pkg::t_status            r_status;
    logic                         r_ovalid;
    isbo_pkg::t_data              r_odata;
    isbo_pkg::t_status            r_ostatus;
    isbo_pkg::t_fill              r_ofill;
    logic                         r_oempty;

    isbo_pkg::t_addr rd_addr;
    isbo_pkg::t_addr wr_addr;
    isbo_pkg::t_data wr_data;
    logic            wr_en;
    isbo_pkg::t_data mul_lo;
    isbo_pkg::t_data div_q;
    logic            div_done;
    logic            div_start;

    always_comb begin
        unique case (i_cmd.rd_sel)
            isbo_pkg::RD_TOP:   rd_addr = isbo_pkg::t_addr'(r_count - isbo_pkg::t_cnt'(1));
            isbo_pkg::RD_POS:   rd_addr = r_pos[isbo_pkg::ADDR_W-1:0];
            isbo_pkg::RD_SWEEP: rd_addr = r_j;
            default:            rd_addr = r_j;
        endcase
        wr_en   = i_cmd.push_wr | i_cmd.sweep_wr;
        wr_addr = i_cmd.push_wr ? isbo_pkg::t_addr'(r_count) : r_j;
        wr_data = i_cmd.push_wr ? r_opnd : r_res;
        mul_lo  = r_q * r_opnd;
    end

    assign div_start = i_cmd.calc && (r_cmd == isbo_pkg::CMD_DIV);

    isbo_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_q),
        .i_divisor  (r_opnd),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd_en) begin
            r_q <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd  <= i_command;
            r_opnd <= isbo_pkg::t_data'(i_operand_value);
            r_pos  <= i_position;
            r_data <= '0;
        end else if (i_cmd.capture) begin
            r_data <= r_q;
        end
        if (i_cmd.st_ld) begin
            r_status <= i_cmd.status;
        end
        if (i_cmd.sweep_clr) begin
            r_j <= '0;
        end else if (i_cmd.sweep_wr) begin
            r_j <= r_j + isbo_pkg::t_addr'(1);
        end
        if (i_cmd.calc) begin
            if (r_cmd == isbo_pkg::CMD_ADD) begin
                r_res <= r_q + r_opnd;
            end else begin
                r_res <= mul_lo;
            end
        end else if (div_done) begin
            r_res <= div_q;
        end
        if (i_cmd.out_load) begin
            r_odata   <= r_data;
            r_ostatus <= r_status;
            r_ofill   <= isbo_pkg::t_fill'(r_count);
            r_oempty  <= (r_count == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cmd.push_wr) begin
                r_count <= r_count + isbo_pkg::t_cnt'(1);
            end else if (i_cmd.pop_dec) begin
                r_count <= r_count - isbo_pkg::t_cnt'(1);
            end
            if (i_cmd.out_load) begin
                r_ovalid <= 1'b1;
            end else if (!i_out_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_stat.cmd        = r_cmd;
        o_stat.is_empty   = (r_count == '0);
        o_stat.is_full    = (r_count == isbo_pkg::t_cnt'(isbo_pkg::DEPTH));
        o_stat.pos_oor    = (isbo_pkg::t_cmp'(r_pos) >= isbo_pkg::t_cmp'(r_count));
        o_stat.opnd_zero  = (r_opnd == '0);
        o_stat.sweep_last = (r_j == isbo_pkg::t_addr'(r_count - isbo_pkg::t_cnt'(1)));
        o_stat.div_done   = div_done;
        o_stat.out_free   = !r_ovalid || !i_out_stall;
    end

    assign o_valid      = r_ovalid;
    assign o_data_out   = signed'(r_odata);
    assign o_status     = r_ostatus;
    assign o_fill_count = r_ofill;
    assign o_is_empty   = r_oempty;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= isbo_pkg::t_cnt'(isbo_pkg::DEPTH))
        else $error("entry count beyond capacity");
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");
    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.push_wr |=> r_count == $past(r_count) + isbo_pkg::t_cnt'(1))
        else $error("push did not grow the count");

endmodule
`default_nettype wire

### rtl/isbo_ctrl.sv
// Command sequencer for the integer stack unit.
`default_nettype none
module isbo_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire isbo_pkg::t_dp_stat i_stat,
    output isbo_pkg::t_dp_cmd       o_cmd
);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_DEC   = 8'b0000_0010,
        S_MRD   = 8'b0000_0100,
        S_BRD   = 8'b0000_1000,
        S_BCALC = 8'b0001_0000,
        S_BWAIT = 8'b0010_0000,
        S_BWR   = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DEC;
                end
            end
            S_DEC: begin
                o_cmd.st_ld  = 1'b1;
                o_cmd.status = isbo_pkg::ST_OK;
                n_state      = S_DONE;
                unique case (i_stat.cmd)
                    isbo_pkg::CMD_PUSH: begin
                        if (i_stat.is_full) begin
                            o_cmd.status = isbo_pkg::ST_FULL;
                        end else begin
                            o_cmd.push_wr = 1'b1;
                        end
                    end
                    isbo_pkg::CMD_POP: begin
                        if (i_stat.is_empty) begin
                            o_cmd.status = isbo_pkg::ST_EMPTY;
                        end else begin
                            o_cmd.rd_en   = 1'b1;
                            o_cmd.rd_sel  = isbo_pkg::RD_TOP;
                            o_cmd.pop_dec = 1'b1;
                            n_state       = S_MRD;
                        end
                    end
                    isbo_pkg::CMD_READ: begin
                        if (i_stat.pos_oor) begin
                            o_cmd.status = isbo_pkg::ST_RANGE;
                        end else begin
                            o_cmd.rd_en  = 1'b1;
                            o_cmd.rd_sel = isbo_pkg::RD_POS;
                            n_state      = S_MRD;
                        end
                    end
                    isbo_pkg::CMD_ADD, isbo_pkg::CMD_MUL: begin
                        if (!i_stat.is_empty) begin
                            o_cmd.sweep_clr = 1'b1;
                            n_state         = S_BRD;
                        end
                    end
                    isbo_pkg::CMD_DIV: begin
                        if (i_stat.opnd_zero) begin
                            o_cmd.status = isbo_pkg::ST_DIVZERO;
                        end else if (!i_stat.is_empty) begin
                            o_cmd.sweep_clr = 1'b1;
                            n_state         = S_BRD;
                        end
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_MRD: begin
                o_cmd.capture = 1'b1;
                n_state       = S_DONE;
            end
            S_BRD: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = isbo_pkg::RD_SWEEP;
                n_state      = S_BCALC;
            end
            S_BCALC: begin
                o_cmd.calc = 1'b1;
                n_state    = (i_stat.cmd == isbo_pkg::CMD_DIV) ? S_BWAIT : S_BWR;
            end
            S_BWAIT: begin
                if (i_stat.div_done) begin
                    n_state = S_BWR;
                end
            end
            S_BWR: begin
                o_cmd.sweep_wr = 1'b1;
                n_state        = i_stat.sweep_last ? S_DONE : S_BRD;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_stall = (r_state != S_IDLE) || !i_rst_n;

    a_div_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_stat.div_done |-> r_state == S_BWAIT)
        else $error("divider completed outside a divide sweep");
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> i_stat.out_free)
        else $error("result register overwritten while occupied");
    a_one_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.push_wr, o_cmd.sweep_wr}))
        else $error("two writes to the entry memory in one cycle");

endmodule
`default_nettype wire
